### hw/rtl/u8dec_pkg.sv
// shared types, constants and helper function for the utf-8 decoder
package u8dec_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned CpW    = 21;
  localparam int unsigned CntW   = 2;
  localparam int unsigned LenW   = 3;
  localparam int unsigned UnitsW = 3;

  localparam logic [ByteW-1:0] Mask2 = 8'hE0;
  localparam logic [ByteW-1:0] Lead2 = 8'hC0;
  localparam logic [ByteW-1:0] Mask3 = 8'hF0;
  localparam logic [ByteW-1:0] Lead3 = 8'hE0;
  localparam logic [ByteW-1:0] Mask4 = 8'hF8;
  localparam logic [ByteW-1:0] Lead4 = 8'hF0;

  localparam logic [CpW-1:0] ReplChar  = 21'h00FFFD;
  localparam logic [CpW-1:0] MaxCp     = 21'h10FFFF;
  localparam logic [CpW-1:0] MaxBmp    = 21'h00FFFF;
  localparam logic [CpW-1:0] Max1Byte  = 21'h00007F;
  localparam logic [CpW-1:0] Max2Byte  = 21'h0007FF;
  localparam logic [CpW-1:0] SurLo     = 21'h00D800;
  localparam logic [CpW-1:0] SurHi     = 21'h00DFFF;
  localparam logic [CpW-1:0] SupBase   = 21'h010000;
  localparam logic [5:0]     HighSurTag = 6'b110110;
  localparam logic [5:0]     LowSurTag  = 6'b110111;

  localparam logic [LenW-1:0] LenNone = 3'd0;
  localparam logic [LenW-1:0] Len2    = 3'd2;
  localparam logic [LenW-1:0] Len3    = 3'd3;
  localparam logic [LenW-1:0] Len4    = 3'd4;

  localparam logic OutFormUtf32 = 1'b0;
  localparam logic OutFormUtf16 = 1'b1;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic pop;
  } u8dec_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic plan_nonempty;
    logic one_left;
  } u8dec_sts_t;

  // scalar value legal for a sequence of the given length
  function automatic logic value_ok(input logic [CpW-1:0] cp, input logic [LenW-1:0] len);
    logic ok;
    ok = 1'b1;
    if (cp > MaxCp) ok = 1'b0;
    if (cp >= SurLo && cp <= SurHi) ok = 1'b0;
    if (len == Len2 && cp <= Max1Byte) ok = 1'b0;
    if (len == Len3 && cp <= Max2Byte) ok = 1'b0;
    if (len == Len4 && cp <= MaxBmp) ok = 1'b0;
    return ok;
  endfunction

endpackage

### hw/rtl/u8dec_dp.sv
// datapath: sequence state, per-item emit plan and output register
module u8dec_dp import u8dec_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_wr_en,
  input  logic             cfg_wr_data,
  input  logic [ByteW-1:0] in_byte,
  input  logic             in_fin,
  input  u8dec_cmd_t       cmd,
  output u8dec_sts_t       sts,
  output logic [CpW-1:0]   out_unit,
  output logic             out_repl,
  output logic             out_run_last,
  output logic             out_done
);

  logic             form_r;
  logic [CntW-1:0]  pcnt_r, pcnt_nxt;
  logic [LenW-1:0]  slen_r, slen_nxt;
  logic [CpW-1:0]   pval_r, pval_nxt;

  logic [UnitsW-1:0] err_left_r, err_nxt;
  logic [CntW-1:0]   pt_cnt_r, pt_cnt_nxt;
  logic [CpW-1:0]    ua_r, ua_nxt;
  logic [CpW-1:0]    ub_r, ub_nxt;
  logic              fin_r;

  logic [CpW-1:0]   unit_r;
  logic             repl_r, run_last_r, done_r;

  logic             cont, pend, has_pt;
  logic [LenW-1:0]  total, lead_len;
  logic [CpW-1:0]   grown, payload, cp, sup;
  logic             one_left;

  // plan for the accepted byte and the next sequence state
  always_comb begin
    cont     = (in_byte[7:6] == 2'b10);
    pend     = (pcnt_r != '0);
    total    = {1'b0, pcnt_r} + LenW'(1);
    grown    = {pval_r[CpW-7:0], in_byte[5:0]};
    err_nxt  = '0;
    has_pt   = 1'b0;
    cp       = '0;
    pcnt_nxt = pcnt_r;
    slen_nxt = slen_r;
    pval_nxt = pval_r;
    lead_len = LenNone;
    payload  = '0;
    if (pend && cont) begin
      if (total >= slen_r) begin
        if (value_ok(grown, slen_r)) begin
          has_pt = 1'b1;
          cp     = grown;
        end else begin
          err_nxt = total;
        end
        pcnt_nxt = '0;
        slen_nxt = LenNone;
        pval_nxt = '0;
      end else if (in_fin) begin
        err_nxt = total;
      end else begin
        pcnt_nxt = total[CntW-1:0];
        pval_nxt = grown;
      end
    end else begin
      if (pend) begin
        err_nxt  = {1'b0, pcnt_r};
        pcnt_nxt = '0;
        slen_nxt = LenNone;
        pval_nxt = '0;
      end
      priority if ((in_byte & Mask2) == Lead2) begin
        lead_len = Len2;
        payload  = {16'b0, in_byte[4:0]};
      end else if ((in_byte & Mask3) == Lead3) begin
        lead_len = Len3;
        payload  = {17'b0, in_byte[3:0]};
      end else if ((in_byte & Mask4) == Lead4) begin
        lead_len = Len4;
        payload  = {18'b0, in_byte[2:0]};
      end else begin
        lead_len = LenNone;
        payload  = '0;
      end
      if (!in_byte[7]) begin
        has_pt = 1'b1;
        cp     = {13'b0, in_byte};
      end else if (lead_len == LenNone || in_fin) begin
        err_nxt = err_nxt + UnitsW'(1);
      end else begin
        pcnt_nxt = CntW'(1);
        slen_nxt = lead_len;
        pval_nxt = payload;
      end
    end
    if (in_fin) begin
      pcnt_nxt = '0;
      slen_nxt = LenNone;
      pval_nxt = '0;
    end
  end

  // split supplementary code points into surrogates when utf-16 is selected
  always_comb begin
    sup        = cp - SupBase;
    pt_cnt_nxt = '0;
    ua_nxt     = cp;
    ub_nxt     = '0;
    if (has_pt) begin
      if (form_r == OutFormUtf16 && cp > MaxBmp) begin
        pt_cnt_nxt = CntW'(2);
        ua_nxt     = {5'b0, HighSurTag, sup[19:10]};
        ub_nxt     = {5'b0, LowSurTag, sup[9:0]};
      end else begin
        pt_cnt_nxt = CntW'(1);
      end
    end
  end

  assign one_left = (err_left_r == UnitsW'(1) && pt_cnt_r == '0) ||
                    (err_left_r == '0 && pt_cnt_r == CntW'(1));

  assign sts.plan_nonempty = (err_nxt != '0) || has_pt;
  assign sts.one_left      = one_left;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      form_r     <= OutFormUtf32;
      pcnt_r     <= '0;
      slen_r     <= LenNone;
      pval_r     <= '0;
      err_left_r <= '0;
      pt_cnt_r   <= '0;
      fin_r      <= 1'b0;
    end else begin
      if (cfg_wr_en) form_r <= cfg_wr_data;
      if (cmd.accept) begin
        pcnt_r     <= pcnt_nxt;
        slen_r     <= slen_nxt;
        pval_r     <= pval_nxt;
        err_left_r <= err_nxt;
        pt_cnt_r   <= pt_cnt_nxt;
        fin_r      <= in_fin;
      end else if (cmd.pop) begin
        if (err_left_r != '0) err_left_r <= err_left_r - UnitsW'(1);
        else pt_cnt_r <= pt_cnt_r - CntW'(1);
      end
    end
  end

  // payload: plan units and output register
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      ua_r <= ua_nxt;
      ub_r <= ub_nxt;
    end else if (cmd.pop && err_left_r == '0) begin
      ua_r <= ub_r;
    end
    if (cmd.pop) begin
      unit_r     <= (err_left_r != '0) ? ReplChar : ua_r;
      repl_r     <= (err_left_r != '0);
      run_last_r <= one_left;
      done_r     <= one_left && fin_r;
    end
  end

  assign out_unit     = unit_r;
  assign out_repl     = repl_r;
  assign out_run_last = run_last_r;
  assign out_done     = done_r;

`ifndef SYNTHESIS
  a_accept_on_drained_plan: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.accept |-> (err_left_r == '0 && pt_cnt_r == '0) || (cmd.pop && one_left))
    else $error("item taken while earlier units still pending");

  a_pop_needs_units: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pop |-> (err_left_r != '0 || pt_cnt_r != '0))
    else $error("unit popped from an empty plan");

  a_open_seq_short: assert property (@(posedge clk) disable iff (!rst_n)
    pcnt_r != '0 |-> ({1'b0, pcnt_r} < slen_r))
    else $error("open sequence holds as many bytes as its length");

  a_plan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (err_left_r + UnitsW'(pt_cnt_r)) <= UnitsW'(4) && (err_left_r == '0 || pt_cnt_r < 2'd2))
    else $error("plan holds more units than one byte can cause");
`endif

endmodule

### hw/rtl/u8dec_ctrl.sv
// controller: accept and emit sequencing, output valid
module u8dec_ctrl import u8dec_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  output logic       out_tvalid,
  input  logic       out_tready,
  input  u8dec_sts_t sts,
  output u8dec_cmd_t cmd
);

  typedef enum logic {
    ST_IDLE,
    ST_EMIT
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free, pop, accept;

  always_comb begin
    out_free  = !out_valid_r || out_tready;
    pop       = (state_r == ST_EMIT) && out_free;
    in_tready = (state_r == ST_IDLE) || (pop && sts.one_left);
    accept    = in_tvalid && in_tready;

    state_nxt = state_r;
    priority if (accept) begin
      state_nxt = sts.plan_nonempty ? ST_EMIT : ST_IDLE;
    end else if (pop && sts.one_left) begin
      state_nxt = ST_IDLE;
    end

    out_valid_nxt = out_valid_r;
    priority if (pop) out_valid_nxt = 1'b1;
    else if (out_tready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign cmd.accept = accept;
  assign cmd.pop    = pop;
  assign out_tvalid = out_valid_r;

endmodule

### hw/rtl/utf8_decoder_to_utf16_or_utf32.sv
// top level: utf-8 byte stream decoder with utf-32 or utf-16 output
// a byte's first unit goes through the plan registers and then the output register
// throughput: one byte per cycle while each byte yields at most one unit and the output is free
// a byte that yields more than one unit (error bursts, surrogate pairs) holds the input until its
// last unit is emitted, one unit per cycle through the single output register when not stalled
// reset (rst_n low, synchronous): open sequence dropped, plan and output emptied, form = utf-32
module utf8_decoder_to_utf16_or_utf32 import u8dec_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  // configuration: output form, 0 utf-32, 1 utf-16
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,
  // byte stream in
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] in_byte
  input  logic        in_tlast,   // final_byte
  // decoded units out
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [20:0] code_unit, [21] run_last, [23:22] zero
  output logic        out_tuser,  // replaced
  output logic        out_tlast   // string_done
);

  u8dec_cmd_t     cmd;
  u8dec_sts_t     sts;
  logic [CpW-1:0] unit;
  logic           run_last;

  // controller decides when to take a byte and when to move a unit to the output
  u8dec_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  // datapath decodes the byte into a plan of units and holds the output payload
  u8dec_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .in_byte      (in_tdata),
    .in_fin       (in_tlast),
    .cmd          (cmd),
    .sts          (sts),
    .out_unit     (unit),
    .out_repl     (out_tuser),
    .out_run_last (run_last),
    .out_done     (out_tlast)
  );

  // pad to whole bytes
  assign out_tdata = {2'b00, run_last, unit};

endmodule
